// File: rtl/csv_tok_pkg.sv
// ----------------------------------------------------------------------------
// csv_tok_pkg
// Shared types and constants for the CSV byte stream tokenizer.
// ----------------------------------------------------------------------------
package csv_tok_pkg;

  localparam int ROW_BITS    = 24;
  localparam int COLUMN_BITS = 16;

  // result queue
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] CH_NUL      = 8'h00;
  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] DELIM_RESET = 8'h2C;

  typedef enum logic [2:0] {
    KIND_START   = 3'd0,
    KIND_BYTE    = 3'd1,
    KIND_COLEND  = 3'd2,
    KIND_ROWEND  = 3'd3,
    KIND_TEXTEND = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    SCAN_BETWEEN  = 2'd0,
    SCAN_UNQUOTED = 2'd1,
    SCAN_QUOTED   = 2'd2
  } scan_e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_t;

  typedef struct packed {
    kind_e                  kind;
    logic [7:0]             value_byte;
    logic [ROW_BITS-1:0]    row_number;
    logic [COLUMN_BITS-1:0] column_number;
    logic                   last_of_run;
  } out_t;

  typedef struct packed {
    scan_e                  scan;
    logic                   pending_quote;
    logic                   after_cr;
    logic [ROW_BITS-1:0]    row;
    logic [COLUMN_BITS-1:0] col;
  } tok_state_t;

  localparam tok_state_t STATE_RESET = '{
    scan:          SCAN_BETWEEN,
    pending_quote: 1'b0,
    after_cr:      1'b0,
    row:           ROW_BITS'(1),
    col:           COLUMN_BITS'(1)
  };

endpackage

// File: rtl/csv_tok_step.sv
// ----------------------------------------------------------------------------
// csv_tok_step
// Next-state and event logic for one text byte: up to two result words.
// ----------------------------------------------------------------------------
module csv_tok_step (
  input  csv_tok_pkg::tok_state_t       state_i,
  input  csv_tok_pkg::in_t              in_i,
  input  logic [7:0]                    delim_i,
  output csv_tok_pkg::tok_state_t       state_o,
  output logic [1:0]                    n_o,
  output csv_tok_pkg::out_t [1:0]       res_o
);

  logic [7:0] b;
  logic       is_end;
  logic       pre_quote;
  logic       text_end;
  logic       plain_byte;
  logic       run_bt;
  logic [1:0] cnt;
  logic [1:0] last_idx;

  assign b      = in_i.text_byte;
  assign is_end = in_i.end_of_text || (b == csv_tok_pkg::CH_NUL);

  always_comb begin
    state_o    = state_i;
    pre_quote  = 1'b0;
    text_end   = 1'b0;
    plain_byte = 1'b0;
    run_bt     = 1'b0;
    cnt        = 2'd0;
    last_idx   = 2'd0;
    for (int i = 0; i < 2; i++) begin
      res_o[i] = '{kind:          csv_tok_pkg::KIND_START,
                   value_byte:    8'h00,
                   row_number:    state_i.row,
                   column_number: state_i.col,
                   last_of_run:   1'b0};
    end

    if (is_end) begin
      pre_quote = (state_i.scan == csv_tok_pkg::SCAN_UNQUOTED) && state_i.pending_quote;
      text_end  = 1'b1;
      state_o   = csv_tok_pkg::STATE_RESET;
    end else begin
      unique case (state_i.scan)
        csv_tok_pkg::SCAN_UNQUOTED: begin
          if (b == delim_i || b == csv_tok_pkg::CH_CR || b == csv_tok_pkg::CH_LF) begin
            pre_quote             = state_i.pending_quote;
            state_o.pending_quote = 1'b0;
            state_o.scan          = csv_tok_pkg::SCAN_BETWEEN;
            run_bt                = 1'b1;
          end else if (b == csv_tok_pkg::CH_QUOTE) begin
            // doubled quote gives one quote byte
            pre_quote             = state_i.pending_quote;
            state_o.pending_quote = !state_i.pending_quote;
          end else begin
            pre_quote             = state_i.pending_quote;
            state_o.pending_quote = 1'b0;
            plain_byte            = 1'b1;
          end
        end
        csv_tok_pkg::SCAN_QUOTED: begin
          if (b == csv_tok_pkg::CH_QUOTE) begin
            pre_quote             = state_i.pending_quote;
            state_o.pending_quote = !state_i.pending_quote;
          end else if (state_i.pending_quote) begin
            // closing quote, this byte is handled between tokens
            state_o.pending_quote = 1'b0;
            state_o.scan          = csv_tok_pkg::SCAN_BETWEEN;
            run_bt                = 1'b1;
          end else begin
            plain_byte = 1'b1;
          end
        end
        default: begin
          state_o.scan          = csv_tok_pkg::SCAN_BETWEEN;
          state_o.pending_quote = 1'b0;
          run_bt                = 1'b1;
        end
      endcase
    end

    if (pre_quote) begin
      res_o[cnt[0]].kind       = csv_tok_pkg::KIND_BYTE;
      res_o[cnt[0]].value_byte = csv_tok_pkg::CH_QUOTE;
      cnt = cnt + 2'd1;
    end
    if (text_end) begin
      res_o[cnt[0]].kind = csv_tok_pkg::KIND_TEXTEND;
      cnt = cnt + 2'd1;
    end
    if (plain_byte) begin
      res_o[cnt[0]].kind       = csv_tok_pkg::KIND_BYTE;
      res_o[cnt[0]].value_byte = b;
      cnt = cnt + 2'd1;
    end

    if (run_bt) begin
      state_o.after_cr = 1'b0;
      if (state_i.after_cr && b == csv_tok_pkg::CH_LF) begin
        // lf of a crlf pair, already counted
      end else if (b == csv_tok_pkg::CH_SPACE || b == csv_tok_pkg::CH_TAB) begin
        // skipped between tokens
      end else if (b == delim_i) begin
        res_o[cnt[0]].kind = csv_tok_pkg::KIND_COLEND;
        cnt = cnt + 2'd1;
        if (state_i.col != {csv_tok_pkg::COLUMN_BITS{1'b1}}) begin
          state_o.col = state_i.col + csv_tok_pkg::COLUMN_BITS'(1);
        end
      end else if (b == csv_tok_pkg::CH_CR || b == csv_tok_pkg::CH_LF) begin
        res_o[cnt[0]].kind = csv_tok_pkg::KIND_ROWEND;
        cnt = cnt + 2'd1;
        if (state_i.row != {csv_tok_pkg::ROW_BITS{1'b1}}) begin
          state_o.row = state_i.row + csv_tok_pkg::ROW_BITS'(1);
        end
        state_o.col      = csv_tok_pkg::COLUMN_BITS'(1);
        state_o.after_cr = (b == csv_tok_pkg::CH_CR);
      end else if (b == csv_tok_pkg::CH_QUOTE) begin
        state_o.scan = csv_tok_pkg::SCAN_QUOTED;
        res_o[cnt[0]].kind = csv_tok_pkg::KIND_START;
        cnt = cnt + 2'd1;
      end else begin
        state_o.scan = csv_tok_pkg::SCAN_UNQUOTED;
        res_o[cnt[0]].kind = csv_tok_pkg::KIND_START;
        cnt = cnt + 2'd1;
        res_o[cnt[0]].kind       = csv_tok_pkg::KIND_BYTE;
        res_o[cnt[0]].value_byte = b;
        cnt = cnt + 2'd1;
      end
    end

    if (cnt != 2'd0) begin
      last_idx = cnt - 2'd1;
      res_o[last_idx[0]].last_of_run = 1'b1;
    end
  end

  assign n_o = cnt;

endmodule

// File: rtl/csv_tok_fifo.sv
// ----------------------------------------------------------------------------
// csv_tok_fifo
// Result queue: takes up to two words per cycle, hands out one per cycle.
// ----------------------------------------------------------------------------
module csv_tok_fifo (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [1:0]                 push_n_i,
  input  csv_tok_pkg::out_t [1:0]    push_data_i,
  input  logic                       pop_i,
  output logic                       room_o,
  output logic                       valid_o,
  output csv_tok_pkg::out_t          data_o
);

  localparam int PtrW = csv_tok_pkg::PTR_W;
  localparam int CntW = csv_tok_pkg::CNT_W;

  csv_tok_pkg::out_t mem_q [csv_tok_pkg::FIFO_DEPTH];

  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] count_after_pop;
  logic            do_pop;
  logic [PtrW-1:0] wr_ptr_next;

  assign valid_o         = (count_q != '0);
  assign data_o          = mem_q[rd_ptr_q];
  assign do_pop          = pop_i && valid_o;
  assign count_after_pop = count_q - CntW'(do_pop);
  // room for the two words one byte may cause
  assign room_o          = (count_after_pop <= CntW'(csv_tok_pkg::FIFO_DEPTH - 2));
  assign wr_ptr_next     = wr_ptr_q + PtrW'(1);

  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrW'(push_n_i);
    rd_ptr_d = rd_ptr_q + PtrW'(do_pop);
    count_d  = count_after_pop + CntW'(push_n_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem_q[wr_ptr_q] <= push_data_i[0];
    end
    if (push_n_i == 2'd2) begin
      mem_q[wr_ptr_next] <= push_data_i[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// File: rtl/csv_byte_stream_tokenizer.sv
// ----------------------------------------------------------------------------
// csv_byte_stream_tokenizer
// CSV tokenizer: one text byte in, value/column/row/text events out.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i/in_ready_o carry one text byte with an end flag.
// Output channel: out_valid_o/out_ready_i carry one event word, each with
// its row and column number and a flag on the last word caused by a byte.
// cfg_we_i writes the delimiter from cfg_wdata_i; write it only while idle.
// A byte goes into an input register, then through the step logic into a
// four-word result queue, from which its first word is offered. One byte
// is taken per cycle as long as the queue has room for two words after
// this cycle's read; a byte with two events needs the single output port
// for two words, so the rate is one byte per cycle when each byte gives
// at most one word, set by the single output port.
// When the receiver stalls the queue fills and in_ready_o drops once fewer
// than two places would be free; nothing is lost.
// Reset clears the queue, the scan state, the counters (row 1, column 1)
// and sets the delimiter to a comma. A text end also clears the scan state
// but keeps the delimiter.
// ----------------------------------------------------------------------------
module csv_byte_stream_tokenizer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  csv_tok_pkg::in_t    in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output csv_tok_pkg::out_t   out_data_o,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i
);

  logic                      in_valid_q, in_valid_d;
  csv_tok_pkg::in_t          in_q;
  csv_tok_pkg::tok_state_t   state_q, state_d, step_state;
  logic [7:0]                delim_q;
  logic [1:0]                step_n;
  csv_tok_pkg::out_t [1:0]   step_res;
  logic [1:0]                push_n;
  logic                      room;
  logic                      consume;
  logic                      in_accept;

  assign consume    = in_valid_q && room;
  assign in_ready_o = !in_valid_q || consume;
  assign in_accept  = in_valid_i && in_ready_o;
  assign push_n     = consume ? step_n : 2'd0;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (consume) begin
      in_valid_d = 1'b0;
    end
    state_d = consume ? step_state : state_q;
  end

  csv_tok_step u_step (
    .state_i (state_q),
    .in_i    (in_q),
    .delim_i (delim_q),
    .state_o (step_state),
    .n_o     (step_n),
    .res_o   (step_res)
  );

  csv_tok_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_n_i    (push_n),
    .push_data_i (step_res),
    .pop_i       (out_ready_i),
    .room_o      (room),
    .valid_o     (out_valid_o),
    .data_o      (out_data_o)
  );

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      state_q    <= csv_tok_pkg::STATE_RESET;
      delim_q    <= csv_tok_pkg::DELIM_RESET;
    end else begin
      in_valid_q <= in_valid_d;
      state_q    <= state_d;
      if (cfg_we_i) begin
        delim_q <= cfg_wdata_i;
      end
    end
  end

endmodule

// File: rtl/csv_tok_checker.sv
// ----------------------------------------------------------------------------
// csv_tok_checker
// Port-level checks on the tokenizer's result channel.
// ----------------------------------------------------------------------------
module csv_tok_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input csv_tok_pkg::out_t out_data_o
);

  // a stalled word stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result word withdrawn while stalled");

  // only value bytes carry a byte
  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind != csv_tok_pkg::KIND_BYTE
      |-> out_data_o.value_byte == 8'h00)
    else $error("nonzero byte on a non-byte event");

  // counters are one-based
  a_pos_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.row_number != '0 && out_data_o.column_number != '0)
    else $error("row or column number is zero");

  // text end is always the last word of its byte
  a_textend_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == csv_tok_pkg::KIND_TEXTEND
      |-> out_data_o.last_of_run)
    else $error("text end not flagged as last");

endmodule

bind csv_byte_stream_tokenizer csv_tok_checker u_csv_tok_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the CSV byte stream tokenizer. Streams directed and
// random CSV text, with noise and broken quoting, under several delimiters,
// predicts every event word in a scoreboard and compares each accepted word
// field by field. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CLK_PERIOD    = 8;
  localparam int          RESET_CYCLES  = 11;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          HOLD_CYCLES   = 400;
  localparam int          STALL_LIMIT   = 4000;
  localparam int          PHASE_ITEMS   = 155;
  localparam int          N_DELIMS      = 10;
  localparam logic [7:0]  DELIM_PLAN [N_DELIMS] = '{
    8'h3B, csv_tok_pkg::CH_NUL, 8'hFF, csv_tok_pkg::CH_SPACE, csv_tok_pkg::CH_TAB,
    csv_tok_pkg::CH_QUOTE, csv_tok_pkg::CH_CR, csv_tok_pkg::CH_LF, 8'h7C,
    csv_tok_pkg::DELIM_RESET
  };

  class csv_event_scoreboard;
    logic [7:0]                          delim;
    csv_tok_pkg::scan_e                  scan;
    bit                                  quote_waiting;
    bit                                  cr_seen;
    logic [csv_tok_pkg::ROW_BITS-1:0]    row;
    logic [csv_tok_pkg::COLUMN_BITS-1:0] col;
    csv_tok_pkg::out_t                   step_events[$];
    csv_tok_pkg::out_t                   expected_events[$];
    int unsigned                         mismatches;
    int unsigned                         events_seen;
    int unsigned                         bytes_noted;

    function new();
      delim = csv_tok_pkg::DELIM_RESET;
      restart();
    endfunction

    function void restart();
      scan          = csv_tok_pkg::SCAN_BETWEEN;
      quote_waiting = 1'b0;
      cr_seen       = 1'b0;
      row           = csv_tok_pkg::ROW_BITS'(1);
      col           = csv_tok_pkg::COLUMN_BITS'(1);
    endfunction

    function void add_event(csv_tok_pkg::kind_e k, logic [7:0] v);
      csv_tok_pkg::out_t e;
      e.kind          = k;
      e.value_byte    = v;
      e.row_number    = row;
      e.column_number = col;
      e.last_of_run   = 1'b0;
      step_events.push_back(e);
    endfunction

    // byte seen outside any value
    function void token_boundary(logic [7:0] b);
      if (cr_seen && b == csv_tok_pkg::CH_LF) begin
        cr_seen = 1'b0;
        return;
      end
      cr_seen = 1'b0;
      if (b == csv_tok_pkg::CH_SPACE || b == csv_tok_pkg::CH_TAB) return;
      if (b == delim) begin
        add_event(csv_tok_pkg::KIND_COLEND, 8'h00);
        if (col != '1) col++;
      end else if (b == csv_tok_pkg::CH_CR || b == csv_tok_pkg::CH_LF) begin
        add_event(csv_tok_pkg::KIND_ROWEND, 8'h00);
        if (row != '1) row++;
        col     = csv_tok_pkg::COLUMN_BITS'(1);
        cr_seen = (b == csv_tok_pkg::CH_CR);
      end else if (b == csv_tok_pkg::CH_QUOTE) begin
        scan = csv_tok_pkg::SCAN_QUOTED;
        add_event(csv_tok_pkg::KIND_START, 8'h00);
      end else begin
        scan = csv_tok_pkg::SCAN_UNQUOTED;
        add_event(csv_tok_pkg::KIND_START, 8'h00);
        add_event(csv_tok_pkg::KIND_BYTE, b);
      end
    endfunction

    function void note_byte(csv_tok_pkg::in_t w);
      logic [7:0] b;
      b = w.text_byte;
      bytes_noted++;
      step_events.delete();
      if (w.end_of_text || b == csv_tok_pkg::CH_NUL) begin
        if (scan == csv_tok_pkg::SCAN_UNQUOTED && quote_waiting)
          add_event(csv_tok_pkg::KIND_BYTE, csv_tok_pkg::CH_QUOTE);
        add_event(csv_tok_pkg::KIND_TEXTEND, 8'h00);
        restart();
      end else if (scan == csv_tok_pkg::SCAN_UNQUOTED) begin
        if (b == delim || b == csv_tok_pkg::CH_CR || b == csv_tok_pkg::CH_LF) begin
          if (quote_waiting) add_event(csv_tok_pkg::KIND_BYTE, csv_tok_pkg::CH_QUOTE);
          quote_waiting = 1'b0;
          scan          = csv_tok_pkg::SCAN_BETWEEN;
          token_boundary(b);
        end else if (b == csv_tok_pkg::CH_QUOTE) begin
          if (quote_waiting) add_event(csv_tok_pkg::KIND_BYTE, csv_tok_pkg::CH_QUOTE);
          quote_waiting = !quote_waiting;
        end else begin
          if (quote_waiting) add_event(csv_tok_pkg::KIND_BYTE, csv_tok_pkg::CH_QUOTE);
          quote_waiting = 1'b0;
          add_event(csv_tok_pkg::KIND_BYTE, b);
        end
      end else if (scan == csv_tok_pkg::SCAN_QUOTED) begin
        if (b == csv_tok_pkg::CH_QUOTE) begin
          if (quote_waiting) add_event(csv_tok_pkg::KIND_BYTE, csv_tok_pkg::CH_QUOTE);
          quote_waiting = !quote_waiting;
        end else if (quote_waiting) begin
          // closing quote: the byte is taken as if between tokens
          quote_waiting = 1'b0;
          scan          = csv_tok_pkg::SCAN_BETWEEN;
          token_boundary(b);
        end else begin
          add_event(csv_tok_pkg::KIND_BYTE, b);
        end
      end else begin
        quote_waiting = 1'b0;
        token_boundary(b);
      end
      if (step_events.size() != 0) step_events[step_events.size()-1].last_of_run = 1'b1;
      foreach (step_events[i]) expected_events.push_back(step_events[i]);
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 40) $display("mismatch at word %0d: %s", events_seen, msg);
    endtask

    task check_event(csv_tok_pkg::out_t got);
      csv_tok_pkg::out_t want;
      events_seen++;
      if (expected_events.size() == 0) begin
        report($sformatf("word of kind %0d with nothing expected", got.kind));
        return;
      end
      want = expected_events.pop_front();
      if (got.kind !== want.kind)
        report($sformatf("kind %0d, expected %0d", got.kind, want.kind));
      if (got.value_byte !== want.value_byte)
        report($sformatf("value_byte %0h, expected %0h", got.value_byte, want.value_byte));
      if (got.row_number !== want.row_number)
        report($sformatf("row %0d, expected %0d", got.row_number, want.row_number));
      if (got.column_number !== want.column_number)
        report($sformatf("column %0d, expected %0d", got.column_number, want.column_number));
      if (got.last_of_run !== want.last_of_run)
        report($sformatf("last_of_run %0b, expected %0b", got.last_of_run, want.last_of_run));
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  csv_tok_pkg::in_t  in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  csv_tok_pkg::out_t out_data;
  logic              cfg_we = 1'b0;
  logic [7:0]        cfg_wdata = 8'h00;

  csv_event_scoreboard sb;
  csv_tok_pkg::in_t    text_q[$];
  bit                  tx_steady;
  bit                  rx_steady;
  bit                  hold_off_req;
  int unsigned         stall_cycles;

  csv_byte_stream_tokenizer dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  always #(CLK_PERIOD/2) clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_content();
    if ($urandom_range(0, 99) < 60) return 8'($urandom_range(1, 255));
    case ($urandom_range(0, 5))
      0:       return csv_tok_pkg::CH_QUOTE;
      1:       return sb.delim;
      2:       return csv_tok_pkg::CH_CR;
      3:       return csv_tok_pkg::CH_LF;
      4:       return csv_tok_pkg::CH_SPACE;
      default: return csv_tok_pkg::CH_TAB;
    endcase
  endfunction

  function automatic void queue_byte(logic [7:0] b, logic eot);
    text_q.push_back(csv_tok_pkg::in_t'{text_byte: b, end_of_text: eot});
  endfunction

  function automatic void queue_text(string s);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i], 1'b0);
  endfunction

  function automatic void queue_value(bit quoted);
    int unsigned n;
    logic [7:0]  b;
    n = $urandom_range(quoted ? 0 : 1, 6);
    if (quoted) queue_byte(csv_tok_pkg::CH_QUOTE, 1'b0);
    repeat (n) begin
      b = pick_content();
      if (!quoted && (b == sb.delim || b == csv_tok_pkg::CH_CR || b == csv_tok_pkg::CH_LF))
        b = 8'h61;
      if (b == csv_tok_pkg::CH_NUL) b = 8'h61;
      if (b == csv_tok_pkg::CH_QUOTE) queue_byte(b, 1'b0);
      queue_byte(b, 1'b0);
    end
    // now and then the quote is left open
    if (quoted && $urandom_range(0, 11) != 0) queue_byte(csv_tok_pkg::CH_QUOTE, 1'b0);
  endfunction

  function automatic void queue_document();
    int unsigned rows;
    int unsigned fields;
    int unsigned n;
    if ($urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 24);
      repeat (n) begin
        if ($urandom_range(0, 3) == 0) queue_byte(pick_content(), $urandom_range(0, 31) == 0);
        else queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 31) == 0);
      end
      queue_byte(8'($urandom_range(0, 255)), 1'b1);
      return;
    end
    rows = $urandom_range(1, 5);
    for (int r = 0; r < rows; r++) begin
      fields = $urandom_range(1, 4);
      for (int f = 0; f < fields; f++) begin
        if (f != 0) queue_byte(sb.delim, 1'b0);
        if ($urandom_range(0, 3) == 0)
          queue_byte($urandom_range(0, 1) ? csv_tok_pkg::CH_SPACE : csv_tok_pkg::CH_TAB, 1'b0);
        case ($urandom_range(0, 4))
          0: ;
          1, 2: queue_value(1'b0);
          3: queue_value(1'b1);
          default: begin
            // text after the closing quote
            queue_value(1'b1);
            queue_value(1'b0);
          end
        endcase
        if ($urandom_range(0, 5) == 0) queue_byte(csv_tok_pkg::CH_SPACE, 1'b0);
      end
      case ($urandom_range(0, 3))
        0: queue_byte(csv_tok_pkg::CH_CR, 1'b0);
        1: queue_byte(csv_tok_pkg::CH_LF, 1'b0);
        2: begin
          queue_byte(csv_tok_pkg::CH_CR, 1'b0);
          queue_byte(csv_tok_pkg::CH_LF, 1'b0);
        end
        default: begin
          if (r + 1 < rows) begin
            queue_byte(csv_tok_pkg::CH_CR, 1'b0);
            queue_byte(csv_tok_pkg::CH_LF, 1'b0);
          end
        end
      endcase
    end
    if ($urandom_range(0, 1)) queue_byte(8'($urandom_range(0, 255)), 1'b1);
    else queue_byte(csv_tok_pkg::CH_NUL, 1'b0);
  endfunction

  task automatic send_queued();
    csv_tok_pkg::in_t w;
    int unsigned      g;
    while (text_q.size() != 0) begin
      w = text_q.pop_front();
      if ($urandom_range(0, 39) == 0) tx_steady = !tx_steady;
      g = tx_steady ? 0 : pick_gap();
      if (g != 0) begin
        in_valid <= 1'b0;
        repeat (g) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_data  <= w;
      do @(posedge clk); while (!in_ready);
      sb.note_byte(w);
    end
  endtask

  // sender stops until every expected word is back, then lets the pipe settle
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_delimiter(logic [7:0] d);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.delim = d;
  endtask

  // receiver: random stalls, steady stretches, and one long hold-off on request
  initial begin
    @(posedge clk iff rst_n);
    forever begin
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        if ($urandom_range(0, 19) == 0) rx_steady = !rx_steady;
        if (!rx_steady) begin
          int unsigned g;
          g = pick_gap();
          if (g != 0) begin
            out_ready <= 1'b0;
            repeat (g) @(posedge clk);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_event(out_data);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", stall_cycles);
      $display("TEST FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed text under the reset delimiter
    queue_text(" a\"\"b\"c,\",\n\"\"\"x\r\n\t");
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h01, 1'b0);
    queue_byte(csv_tok_pkg::CH_LF, 1'b0);
    queue_text("q\"");
    queue_byte(8'hA5, 1'b1);
    queue_text("\"z");
    queue_byte(csv_tok_pkg::CH_NUL, 1'b0);
    send_queued();

    for (int p = 0; p < N_DELIMS; p++) begin
      write_delimiter(DELIM_PLAN[p]);
      if (p == 2) hold_off_req = 1'b1;
      while (text_q.size() < PHASE_ITEMS) queue_document();
      send_queued();
    end

    // back to the comma for a short closing text
    write_delimiter(csv_tok_pkg::DELIM_RESET);
    queue_text("v,,\r\nw");
    queue_byte(csv_tok_pkg::CH_NUL, 1'b1);
    send_queued();
    drain();

    if (sb.expected_events.size() != 0)
      sb.report($sformatf("%0d words never arrived", sb.expected_events.size()));
    $display("covered %0d text bytes and %0d event words over %0d delimiter settings",
             sb.bytes_noted, sb.events_seen, N_DELIMS + 1);
    $display("with random stalls on both sides and one long receiver hold-off");
    if (sb.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
